// File: src/ptsa_pkg.sv
// Shared types and constants of the pulse trace soft ADC.
// Used by the channel interfaces, by ptsa_trace_acc and by the top level of the block.
package ptsa_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int TIME_W    = 48;
  localparam int VALUE_W   = 48;
  localparam int GAIN_W    = 32;
  localparam int OFFSET_W  = 32;
  localparam int SPACING_W = 32;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 5;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
  localparam int V_W       = 42;
  localparam int MAG_W     = 42;
  localparam int SUM_W     = 64;
  localparam int SHIFT_AMT = 8;

  localparam int MAX_TRACE_LENGTH_DEF = 4096;

  localparam logic [GAIN_W-1:0]    GAIN_RST    = 32'h0100_0000;
  localparam logic [OFFSET_W-1:0]  OFFSET_RST  = 32'h0000_0000;
  localparam logic [SPACING_W-1:0] SPACING_RST = 32'h0000_0001;

  typedef enum logic [1:0] {
    MODE_NONE     = 2'd0,
    MODE_MEAN     = 2'd1,
    MODE_MAX_ABS  = 2'd2,
    MODE_MEAN_ABS = 2'd3
  } adc_mode_t;

  typedef enum logic [2:0] {
    REG_ADC_MODE        = 3'd0,
    REG_NARROW_SAMPLES  = 3'd1,
    REG_VERTICAL_GAIN   = 3'd2,
    REG_BASELINE_OFFSET = 3'd3,
    REG_SAMPLE_SPACING  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_ABS,
    ST_ACC,
    ST_END,
    ST_DIV,
    ST_SIGN,
    ST_TIME,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic scale;
    logic absv;
    logic acc;
    logic clear;
  } acc_ctl_t;

endpackage

// File: src/ptsa_if.sv
// Valid/ready channel interfaces for sample items and result items.
// Depends on ptsa_pkg for field widths.
interface ptsa_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ptsa_pkg::SAMPLE_W-1:0] sample;
  logic        [ptsa_pkg::TIME_W-1:0]   pulse_time;
  logic                                 last_sample;

  modport source(output valid, sample, pulse_time, last_sample, input ready);
  modport sink(input valid, sample, pulse_time, last_sample, output ready);
endinterface

interface ptsa_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [ptsa_pkg::VALUE_W-1:0] adc_value;
  logic        [ptsa_pkg::TIME_W-1:0]  pulse_center_time;

  modport source(output valid, adc_value, pulse_center_time, input ready);
  modport sink(input valid, adc_value, pulse_center_time, output ready);
endinterface

// File: src/ptsa_trace_acc.sv
// Per-sample datapath: scale, magnitude, running sum, peak, count and pulse time.
// Stepped by the sequencer in the top level; depends on ptsa_pkg.
module ptsa_trace_acc #(
  parameter int MAX_TRACE_LENGTH = ptsa_pkg::MAX_TRACE_LENGTH_DEF,
  parameter int CNT_W            = $clog2(MAX_TRACE_LENGTH + 1)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  ptsa_pkg::acc_ctl_t                    ctl,
  input  ptsa_pkg::adc_mode_t                   adc_mode,
  input  logic                                  narrow_samples,
  input  logic        [ptsa_pkg::GAIN_W-1:0]    vertical_gain,
  input  logic signed [ptsa_pkg::OFFSET_W-1:0]  baseline_offset,
  input  logic signed [ptsa_pkg::SAMPLE_W-1:0]  sample,
  input  logic        [ptsa_pkg::TIME_W-1:0]    pulse_time,
  output logic signed [ptsa_pkg::SUM_W-1:0]     value_sum,
  output logic        [ptsa_pkg::MAG_W-1:0]     peak_magnitude,
  output logic        [CNT_W-1:0]               sample_count,
  output logic        [ptsa_pkg::TIME_W-1:0]    held_pulse_time,
  output logic                                  count_full
);

  logic signed [ptsa_pkg::SAMPLE_W-1:0] x_r;
  logic signed [ptsa_pkg::PROD_W-1:0]   prod_r;
  logic signed [ptsa_pkg::V_W-1:0]      v_r;
  logic        [ptsa_pkg::MAG_W-1:0]    mag_r;
  logic signed [ptsa_pkg::SUM_W-1:0]    sum_r;
  logic        [ptsa_pkg::MAG_W-1:0]    peak_r;
  logic        [CNT_W-1:0]              count_r;
  logic        [ptsa_pkg::TIME_W-1:0]   held_r;
  logic                                 at_start_r;

  logic signed [ptsa_pkg::SAMPLE_W-1:0] x_nxt;
  logic signed [ptsa_pkg::PROD_W-1:0]   prod_nxt;
  logic signed [ptsa_pkg::V_W-1:0]      v_nxt;
  logic        [ptsa_pkg::MAG_W-1:0]    mag_nxt;
  logic signed [ptsa_pkg::SUM_W-1:0]    sum_nxt;

  assign x_nxt    = narrow_samples ? {{8{sample[7]}}, sample[7:0]} : sample;
  assign prod_nxt = $signed(x_r) * $signed({1'b0, vertical_gain});
  assign v_nxt    = ptsa_pkg::V_W'(prod_r >>> ptsa_pkg::SHIFT_AMT)
                  - ptsa_pkg::V_W'(baseline_offset);
  assign mag_nxt  = v_r[ptsa_pkg::V_W-1] ? ptsa_pkg::MAG_W'(-v_r) : ptsa_pkg::MAG_W'(v_r);

  always_comb begin
    unique case (adc_mode)
      ptsa_pkg::MODE_MEAN:     sum_nxt = sum_r + ptsa_pkg::SUM_W'(v_r);
      ptsa_pkg::MODE_MEAN_ABS: sum_nxt = sum_r + $signed({{(ptsa_pkg::SUM_W-ptsa_pkg::MAG_W){1'b0}},
                                                          mag_r});
      default:                 sum_nxt = sum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r <= x_nxt;
    end
    if (ctl.mul) begin
      prod_r <= prod_nxt;
    end
    if (ctl.scale) begin
      v_r <= v_nxt;
    end
    if (ctl.absv) begin
      mag_r <= mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      sum_r      <= '0;
      peak_r     <= '0;
      count_r    <= '0;
      held_r     <= '0;
      at_start_r <= 1'b1;
    end else begin
      if (ctl.load && at_start_r) begin
        held_r     <= pulse_time;
        at_start_r <= 1'b0;
      end
      if (ctl.acc) begin
        sum_r   <= sum_nxt;
        count_r <= count_r + CNT_W'(1);
        if (mag_r > peak_r) begin
          peak_r <= mag_r;
        end
      end
    end
  end

  assign value_sum       = sum_r;
  assign peak_magnitude  = peak_r;
  assign sample_count    = count_r;
  assign held_pulse_time = held_r;
  assign count_full      = (count_r >= CNT_W'(MAX_TRACE_LENGTH));

endmodule

// File: src/ptsa_div.sv
// Restoring divider, one quotient bit per cycle, for unsigned operands.
// Started by the top-level sequencer; depends on no package.
module ptsa_div #(
  parameter int DVD_W = 64,
  parameter int DVS_W = 13
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;

  logic [DVS_W:0]    shifted;
  logic              fits;
  logic [DVS_W:0]    diff;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign fits    = (shifted >= {1'b0, dvs_r});
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DVD_W);
      end else if (busy_r) begin
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: src/pulse_trace_soft_adc_core.sv
// Pulse trace soft ADC top level: register port, sequencer, divider and result register.
// Depends on ptsa_pkg, ptsa_if, ptsa_trace_acc and ptsa_div.
//
// Takes one trace sample per item and, on the sample flagged last, delivers the trace mean,
// peak magnitude or mean magnitude with a center timestamp (adc_mode 0 delivers nothing).
// A counted sample runs through accept, multiply, scale, magnitude and accumulate before the
// next is taken; one beyond MAX_TRACE_LENGTH is dropped at accept. After the last sample,
// maximum mode runs the end, time and emit states; the mean modes add divide and sign,
// where the restoring divider retires one quotient bit per cycle. The result register frees
// the input while a result waits; a second result waits until the first is taken. Registers
// sit at byte address 4*i; the user writes them only while the block is idle (not checked).
module pulse_trace_soft_adc_core #(
  parameter int MAX_TRACE_LENGTH = ptsa_pkg::MAX_TRACE_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptsa_pkg::ADDR_W-1:0]   paddr,
  input  logic [ptsa_pkg::DATA_W-1:0]   pwdata,
  output logic [ptsa_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  ptsa_in_if.sink                       in_item,
  ptsa_out_if.source                    out_item
);

  localparam int CNT_W = $clog2(MAX_TRACE_LENGTH + 1);
  localparam int TSP_W = CNT_W + 1 + ptsa_pkg::SPACING_W;

  ptsa_pkg::adc_mode_t                  mode_r;
  logic                                 narrow_r;
  logic        [ptsa_pkg::GAIN_W-1:0]   gain_r;
  logic signed [ptsa_pkg::OFFSET_W-1:0] offset_r;
  logic        [ptsa_pkg::SPACING_W-1:0] spacing_r;

  ptsa_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = ptsa_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= ptsa_pkg::MODE_NONE;
      narrow_r  <= 1'b0;
      gain_r    <= ptsa_pkg::GAIN_RST;
      offset_r  <= ptsa_pkg::OFFSET_RST;
      spacing_r <= ptsa_pkg::SPACING_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ptsa_pkg::REG_ADC_MODE:        mode_r    <= ptsa_pkg::adc_mode_t'(pwdata[1:0]);
        ptsa_pkg::REG_NARROW_SAMPLES:  narrow_r  <= pwdata[0];
        ptsa_pkg::REG_VERTICAL_GAIN:   gain_r    <= pwdata;
        ptsa_pkg::REG_BASELINE_OFFSET: offset_r  <= pwdata;
        ptsa_pkg::REG_SAMPLE_SPACING:  spacing_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ptsa_pkg::REG_ADC_MODE:        prdata = {30'd0, mode_r};
      ptsa_pkg::REG_NARROW_SAMPLES:  prdata = {31'd0, narrow_r};
      ptsa_pkg::REG_VERTICAL_GAIN:   prdata = gain_r;
      ptsa_pkg::REG_BASELINE_OFFSET: prdata = offset_r;
      ptsa_pkg::REG_SAMPLE_SPACING:  prdata = spacing_r;
      default:                       prdata = '0;
    endcase
  end

  ptsa_pkg::acc_ctl_t                   ctl;
  logic signed [ptsa_pkg::SUM_W-1:0]    value_sum;
  logic        [ptsa_pkg::MAG_W-1:0]    peak_magnitude;
  logic        [CNT_W-1:0]              sample_count;
  logic        [ptsa_pkg::TIME_W-1:0]   held_pulse_time;
  logic                                 count_full;

  ptsa_trace_acc #(
    .MAX_TRACE_LENGTH(MAX_TRACE_LENGTH),
    .CNT_W           (CNT_W)
  ) u_acc (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .adc_mode       (mode_r),
    .narrow_samples (narrow_r),
    .vertical_gain  (gain_r),
    .baseline_offset(offset_r),
    .sample         (in_item.sample),
    .pulse_time     (in_item.pulse_time),
    .value_sum      (value_sum),
    .peak_magnitude (peak_magnitude),
    .sample_count   (sample_count),
    .held_pulse_time(held_pulse_time),
    .count_full     (count_full)
  );

  logic                         div_start;
  logic                         div_done;
  logic [ptsa_pkg::SUM_W-1:0]   div_dividend;
  logic [ptsa_pkg::SUM_W-1:0]   div_quotient;

  assign div_dividend = value_sum[ptsa_pkg::SUM_W-1] ? ptsa_pkg::SUM_W'(-value_sum)
                                                     : ptsa_pkg::SUM_W'(value_sum);

  ptsa_div #(
    .DVD_W(ptsa_pkg::SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (sample_count),
    .done    (div_done),
    .quotient(div_quotient)
  );

  ptsa_pkg::state_t state_r;
  ptsa_pkg::state_t state_nxt;

  logic                                last_r;
  logic [TSP_W-1:0]                    ts_prod_r;
  logic signed [ptsa_pkg::VALUE_W-1:0] res_r;
  logic [ptsa_pkg::TIME_W-1:0]         center_r;
  logic                                out_valid_r;
  logic signed [ptsa_pkg::VALUE_W-1:0] out_value_r;
  logic [ptsa_pkg::TIME_W-1:0]         out_center_r;

  logic [CNT_W:0]                      half_count;
  logic [TSP_W-1:0]                    ts_prod_nxt;
  logic [ptsa_pkg::VALUE_W-1:0]        quo_low;
  logic                                in_fire;
  logic                                ts_load;
  logic                                res_peak_load;
  logic                                res_div_load;
  logic                                center_load;
  logic                                out_load;

  assign half_count  = {1'b0, sample_count} >> 1;
  assign ts_prod_nxt = half_count * spacing_r;
  assign quo_low     = div_quotient[ptsa_pkg::VALUE_W-1:0];
  assign in_fire     = in_item.valid && in_item.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    in_item.ready = 1'b0;
    div_start     = 1'b0;
    ts_load       = 1'b0;
    res_peak_load = 1'b0;
    res_div_load  = 1'b0;
    center_load   = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ptsa_pkg::ST_IDLE: begin
        in_item.ready = 1'b1;
        if (in_item.valid) begin
          ctl.load = 1'b1;
          priority if (!count_full) begin
            state_nxt = ptsa_pkg::ST_MUL;
          end else if (in_item.last_sample) begin
            state_nxt = ptsa_pkg::ST_END;
          end else begin
            state_nxt = ptsa_pkg::ST_IDLE;
          end
        end
      end
      ptsa_pkg::ST_MUL: begin
        ctl.mul   = 1'b1;
        state_nxt = ptsa_pkg::ST_SCALE;
      end
      ptsa_pkg::ST_SCALE: begin
        ctl.scale = 1'b1;
        state_nxt = ptsa_pkg::ST_ABS;
      end
      ptsa_pkg::ST_ABS: begin
        ctl.absv  = 1'b1;
        state_nxt = ptsa_pkg::ST_ACC;
      end
      ptsa_pkg::ST_ACC: begin
        ctl.acc   = 1'b1;
        state_nxt = last_r ? ptsa_pkg::ST_END : ptsa_pkg::ST_IDLE;
      end
      ptsa_pkg::ST_END: begin
        unique case (mode_r)
          ptsa_pkg::MODE_NONE: begin
            ctl.clear = 1'b1;
            state_nxt = ptsa_pkg::ST_IDLE;
          end
          ptsa_pkg::MODE_MAX_ABS: begin
            ts_load       = 1'b1;
            res_peak_load = 1'b1;
            state_nxt     = ptsa_pkg::ST_TIME;
          end
          default: begin
            ts_load   = 1'b1;
            div_start = 1'b1;
            state_nxt = ptsa_pkg::ST_DIV;
          end
        endcase
      end
      ptsa_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = ptsa_pkg::ST_SIGN;
        end
      end
      ptsa_pkg::ST_SIGN: begin
        res_div_load = 1'b1;
        state_nxt    = ptsa_pkg::ST_TIME;
      end
      ptsa_pkg::ST_TIME: begin
        center_load = 1'b1;
        state_nxt   = ptsa_pkg::ST_EMIT;
      end
      ptsa_pkg::ST_EMIT: begin
        if (!out_valid_r || out_item.ready) begin
          out_load  = 1'b1;
          ctl.clear = 1'b1;
          state_nxt = ptsa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ptsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      last_r <= in_item.last_sample;
    end
    if (ts_load) begin
      ts_prod_r <= ts_prod_nxt;
    end
    if (res_peak_load) begin
      res_r <= $signed(ptsa_pkg::VALUE_W'(peak_magnitude));
    end else if (res_div_load) begin
      res_r <= value_sum[ptsa_pkg::SUM_W-1] ? $signed(-quo_low) : $signed(quo_low);
    end
    if (center_load) begin
      center_r <= held_pulse_time + ptsa_pkg::TIME_W'(ts_prod_r);
    end
    if (out_load) begin
      out_value_r  <= res_r;
      out_center_r <= center_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_item.valid             = out_valid_r;
  assign out_item.adc_value         = out_value_r;
  assign out_item.pulse_center_time = out_center_r;

endmodule

// File: verif/ptsa_checker.sv
// Checker for the pulse trace soft ADC: snoops register writes, sample items and result items.
// Predicts each pulse result and compares it field by field; depends on ptsa_pkg and ptsa_if.
`timescale 1ns / 1ps
module ptsa_checker #(
  parameter int MAX_LEN = ptsa_pkg::MAX_TRACE_LENGTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [ptsa_pkg::ADDR_W-1:0] paddr,
  input  logic [ptsa_pkg::DATA_W-1:0] pwdata,
  ptsa_in_if                          in_mon,
  ptsa_out_if                         out_mon,
  output int                          mismatches,
  output int                          pending
);
  import ptsa_pkg::*;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [TIME_W-1:0]         center;
  } pulse_result_t;

  pulse_result_t pulse_results_q[$];

  adc_mode_t                   cfg_mode;
  logic                        cfg_narrow;
  logic [GAIN_W-1:0]           cfg_gain;
  logic signed [OFFSET_W-1:0]  cfg_offset;
  logic [SPACING_W-1:0]        cfg_spacing;

  longint            trace_sum;
  longint            trace_peak;
  int                trace_count;
  logic [TIME_W-1:0] trace_start;
  logic              trace_open;

  task automatic clear_trace();
    trace_sum = 0;
    trace_peak = 0;
    trace_count = 0;
    trace_start = '0;
    trace_open = 1'b1;
  endtask

  task automatic apply_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    case (reg_idx_t'(addr[4:2]))
      REG_ADC_MODE:        cfg_mode = adc_mode_t'(data[1:0]);
      REG_NARROW_SAMPLES:  cfg_narrow = data[0];
      REG_VERTICAL_GAIN:   cfg_gain = data;
      REG_BASELINE_OFFSET: cfg_offset = data;
      REG_SAMPLE_SPACING:  cfg_spacing = data;
      default: ;
    endcase
  endtask

  task automatic integrate_sample(logic signed [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t,
                                  logic last);
    longint        x;
    longint        v;
    longint        mag;
    longint        res;
    pulse_result_t r;
    if (trace_open) begin
      trace_start = t;
      trace_open = 1'b0;
    end
    x = cfg_narrow ? longint'($signed(s[7:0])) : longint'(s);
    if (trace_count < MAX_LEN) begin
      v = ((x * longint'(cfg_gain)) >>> SHIFT_AMT) - longint'(cfg_offset);
      mag = (v < 0) ? -v : v;
      if (cfg_mode == MODE_MEAN) trace_sum += v;
      else if (cfg_mode == MODE_MEAN_ABS) trace_sum += mag;
      if (mag > trace_peak) trace_peak = mag;
      trace_count++;
    end
    if (last) begin
      if (cfg_mode != MODE_NONE) begin
        if (cfg_mode == MODE_MAX_ABS) res = trace_peak;
        else res = (trace_count != 0) ? trace_sum / longint'(trace_count) : 0;
        r.value = res[VALUE_W-1:0];
        r.center = trace_start
                 + TIME_W'(longint'(trace_count >> 1) * longint'(cfg_spacing));
        pulse_results_q.push_back(r);
      end
      clear_trace();
    end
  endtask

  task automatic compare_result(logic signed [VALUE_W-1:0] value, logic [TIME_W-1:0] center);
    pulse_result_t exp_r;
    if (pulse_results_q.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result item: adc_value %0d pulse_center_time 0x%012h",
               $time, value, center);
    end else begin
      exp_r = pulse_results_q.pop_front();
      if (value !== exp_r.value) begin
        mismatches++;
        $display("%0t: adc_value expected %0d actual %0d", $time, exp_r.value, value);
      end
      if (center !== exp_r.center) begin
        mismatches++;
        $display("%0t: pulse_center_time expected 0x%012h actual 0x%012h",
                 $time, exp_r.center, center);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode = MODE_NONE;
      cfg_narrow = 1'b0;
      cfg_gain = GAIN_RST;
      cfg_offset = OFFSET_RST;
      cfg_spacing = SPACING_RST;
      clear_trace();
      pulse_results_q.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
      if (out_mon.valid && out_mon.ready)
        compare_result(out_mon.adc_value, out_mon.pulse_center_time);
      if (in_mon.valid && in_mon.ready)
        integrate_sample(in_mon.sample, in_mon.pulse_time, in_mon.last_sample);
    end
    pending = pulse_results_q.size();
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the pulse trace soft ADC: clock, reset, register writes and sample traces.
// Depends on ptsa_pkg, ptsa_if, the core and ptsa_checker, which predicts and compares.
`timescale 1ns / 1ps
module tb_top;
  import ptsa_pkg::*;

  localparam int MAX_LEN    = MAX_TRACE_LENGTH_DEF;
  localparam int SETTLE     = 100;
  localparam int HOLD_OFF   = 400;
  localparam int LIMIT      = 1000000;
  localparam int ITEM_GOAL  = 1550;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatches;
  int pending;
  int cycle_count;
  int samples_sent;
  bit src_idle_en;
  bit snk_idle_en;
  bit hold_req;

  ptsa_in_if  in_ch();
  ptsa_out_if out_ch();

  pulse_trace_soft_adc_core #(.MAX_TRACE_LENGTH(MAX_LEN)) dut (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_item(in_ch), .out_item(out_ch)
  );

  ptsa_checker #(.MAX_LEN(MAX_LEN)) u_checker (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .pready(pready), .paddr(paddr), .pwdata(pwdata), .in_mon(in_ch), .out_mon(out_ch),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return SAMPLE_W'($urandom_range(0, 64) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(0, 7))
      0: return '1;
      1: return '0;
      default: return TIME_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return GAIN_RST;
      3: return $urandom_range(0, 32'h0400_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      3: return DATA_W'($urandom_range(0, 32'h0020_0000) - 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_spacing();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h1;
      3: return $urandom_range(1, 1000);
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(logic [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t, logic last);
    int gap;
    gap = src_idle_en ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.pulse_time <= t;
    in_ch.last_sample <= last;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    samples_sent++;
  endtask

  task automatic send_trace(int len);
    for (int i = 0; i < len; i++)
      send_sample(rand_sample(), rand_time(), i == len - 1);
  endtask

  // let every result drain, then give the block time to settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_all(adc_mode_t mode, logic narrow, logic [DATA_W-1:0] gain,
                           logic [DATA_W-1:0] offset, logic [DATA_W-1:0] spacing);
    write_reg(REG_ADC_MODE, DATA_W'(mode));
    write_reg(REG_NARROW_SAMPLES, DATA_W'(narrow));
    write_reg(REG_VERTICAL_GAIN, gain);
    write_reg(REG_BASELINE_OFFSET, offset);
    write_reg(REG_SAMPLE_SPACING, spacing);
  endtask

  initial begin : result_sink
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        gap = HOLD_OFF;
        hold_req = 1'b0;
      end else begin
        gap = snk_idle_en ? $urandom_range(0, 11) : 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin : stimulus
    int        phase;
    int        n_traces;
    int        len;
    adc_mode_t mode;
    samples_sent = 0;
    hold_req = 1'b0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    rst_n <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.pulse_time <= '0;
    in_ch.last_sample <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no result, trace still closes
    send_sample(16'h7FFF, '1, 1'b0);
    send_sample(16'h8000, '0, 1'b1);
    drain();

    write_all(MODE_MEAN, 1'b0, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(16'h7FFF, '1, 1'b0);
    send_sample(16'h8000, '0, 1'b0);
    send_sample(16'h0000, '1, 1'b0);
    send_sample(16'hFFFF, '0, 1'b1);
    drain();

    write_all(MODE_MAX_ABS, 1'b0, GAIN_RST, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_sample(16'h8000, 48'h8000_0000_0000, 1'b1);
    drain();

    write_all(MODE_MEAN_ABS, 1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0003);
    send_sample(16'hFF80, 48'h0000_0000_0001, 1'b0);
    send_sample(16'h007F, '1, 1'b0);
    send_sample(16'h5A12, '0, 1'b1);
    drain();

    // switch mode in the middle of a trace
    write_all(MODE_MEAN, 1'b0, 32'h0123_4567, 32'h0001_0000, 32'h0000_0007);
    send_sample(16'h8000, 48'hFFFF_FFFF_FFF0, 1'b0);
    send_sample(16'h1234, '0, 1'b0);
    drain();
    write_reg(REG_ADC_MODE, DATA_W'(MODE_MEAN_ABS));
    send_sample(16'h7FFF, '0, 1'b0);
    send_sample(16'hC000, '0, 1'b1);
    drain();

    write_all(MODE_MEAN, 1'b0, 32'h0, 32'h0, 32'h0);
    send_sample(16'h7FFF, 48'h1234_5678_9ABC, 1'b1);
    drain();

    // overlong trace: samples past the limit are dropped
    write_all(MODE_MEAN, 1'b0, pick_gain(), pick_offset(), pick_spacing());
    src_idle_en = 1'b0;
    send_trace(MAX_LEN + 4);
    drain();
    samples_sent = 0;

    phase = 0;
    while (samples_sent < ITEM_GOAL) begin
      mode = ($urandom_range(0, 7) == 0) ? MODE_NONE : adc_mode_t'($urandom_range(1, 3));
      write_all(mode, 1'($urandom), pick_gain(), pick_offset(), pick_spacing());
      src_idle_en = ($urandom_range(0, 3) != 0);
      snk_idle_en = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // hold the receiver off while short traces pile up
        write_reg(REG_ADC_MODE, DATA_W'(MODE_MAX_ABS));
        src_idle_en = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) send_trace(1);
      end else begin
        n_traces = $urandom_range(3, 10);
        for (int i = 0; i < n_traces; i++) begin
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
          send_trace(len);
        end
      end
      drain();
      phase++;
    end

    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
